### rtl/box_mean_filter_macros.svh
// Assertion macros for the box mean filter RTL.
`ifndef BOX_MEAN_FILTER_MACROS_SVH
`define BOX_MEAN_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define BMF_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define BMF_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bmf_pkg.sv
// Shared constants, register codes and pipeline types of the box mean filter.
package bmf_pkg;

	localparam int PIX_W       = 8;
	localparam int WIN         = 5;
	localparam int STORE_LINES = 4;
	localparam int DIM_W       = 10;
	localparam int POS_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int RADIUS_W    = 2;

	// column sums: three rows and five rows of 8-bit pixels
	localparam int COL3_W = 10;
	localparam int COL5_W = 11;
	localparam int SUM_W  = 13;

	// floor(x / 9) = (x * 7282) >> 16 for x < 32768
	// floor(x / 25) = (x * 20972) >> 19 for x < 43690
	localparam int DIV_K_W     = 15;
	localparam int DIV9_MUL    = 7282;
	localparam int DIV9_SHIFT  = 16;
	localparam int DIV25_MUL   = 20972;
	localparam int DIV25_SHIFT = 19;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;

	localparam logic [RADIUS_W-1:0] RADIUS_5X5    = 2'd2;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 2'd1;
	localparam logic [DIM_W-1:0]    WIDTH_RESET   = 10'd512;
	localparam logic [DIM_W-1:0]    HEIGHT_RESET  = 10'd512;
	localparam logic [DIM_W-1:0]    MIN_DIM       = 10'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_RADIUS = 2'd0,
		REG_IMAGE_WIDTH   = 2'd1,
		REG_IMAGE_HEIGHT  = 2'd2
	} cfg_reg_t;

	// per-pixel bookkeeping that rides along the pipeline
	typedef struct packed {
		logic             interior;
		logic             last;
		logic             rad2;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} bmf_meta_t;

endpackage

### rtl/bmf_line_store.sv
// Four line store banks: on each beat every bank is read and the bank named by slot is written, at the current column.
module bmf_line_store import bmf_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [1:0]                            slot,
	input  logic [ADDR_W-1:0]                     addr,
	input  logic [PIX_W-1:0]                      wdata,
	output logic [STORE_LINES-1:0][PIX_W-1:0]     rd
);

	for (genvar b = 0; b < STORE_LINES; b++) begin : g_bank
		logic [PIX_W-1:0] bank_q [MAX_WIDTH];
		logic [PIX_W-1:0] rd_q;

		// read-before-write: the old row comes out, the new pixel goes in
		always_ff @(posedge clk) begin
			if (en) begin
				rd_q <= bank_q[addr];
				if (slot == 2'(b)) begin
					bank_q[addr] <= wdata;
				end
			end
		end

		assign rd[b] = rd_q;
	end

endmodule

### rtl/bmf_win_cell.sv
// One window column cell: holds the 3-row and 5-row sums of a column and hands them left.
module bmf_win_cell import bmf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic [COL3_W-1:0] sum3_in,
	input  logic [COL5_W-1:0] sum5_in,
	output logic [COL3_W-1:0] sum3,
	output logic [COL5_W-1:0] sum5
);

	logic [COL3_W-1:0] sum3_q;
	logic [COL5_W-1:0] sum5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum3_q <= '0;
			sum5_q <= '0;
		end else if (shift) begin
			sum3_q <= sum3_in;
			sum5_q <= sum5_in;
		end
	end

	assign sum3 = sum3_q;
	assign sum5 = sum5_q;

endmodule

### rtl/box_mean_filter.sv
// Top level of the streaming 3x3 / 5x5 box mean filter.
//
// Grey pixels enter in raster order, one beat per clock, and the block keeps
// up with that rate while the output is not stalled: every stage advances in
// each cycle that the output skid entry is empty, and only a full skid entry
// holds the input off. A result passes the line store read, the window cell
// shift, the window sum and the divide into the output register. Four line
// store banks of MAX_WIDTH x 8 bits supply the rows above: on each beat all
// four banks are read at the current column and one is written there; a
// chain of five window cells holds the column sums and shifts each beat. The
// mean is the window sum times a reciprocal constant, so no divider is
// needed. Only interior pixels, whose whole window lies inside the frame,
// give a result; it carries the centre row and column and frame_last on the
// final interior pixel. The line stores are not cleared after reset, so
// the first rows of the very first frame after reset read undefined data,
// but those rows only feed border windows, which give no result. Write the
// configuration registers (radius, width, height) only while the block is
// idle; widths and heights outside 3..MAX are clamped, radius codes other
// than 2 select the 3x3 mean.
`include "box_mean_filter_macros.svh"

module box_mean_filter import bmf_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// pixel input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     pixel,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     mean_value,
	output logic [POS_W-1:0]     centre_row,
	output logic [POS_W-1:0]     centre_col,
	output logic                 frame_last,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int CNT_W = (CW > RW) ? CW : RW;
	// wide enough for counters plus one and for the 10-bit size registers
	localparam int SW    = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
	localparam int PROD_W = SUM_W + DIV_K_W;

	// ------------------------------------------------------------------
	// Configuration registers. The port never pushes back.
	// ------------------------------------------------------------------
	logic [RADIUS_W-1:0] kernel_radius_q;
	logic [DIM_W-1:0]    image_width_q;
	logic [DIM_W-1:0]    image_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_radius_q <= RADIUS_RESET;
			image_width_q   <= WIDTH_RESET;
			image_height_q  <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KERNEL_RADIUS: kernel_radius_q <= cfg_data[RADIUS_W-1:0];
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				default: begin
					// writes past the register list are dropped
				end
			endcase
		end
	end

	// Clamp the frame size to what the counters and line stores support.
	logic [SW-1:0] w_eff;
	logic [SW-1:0] h_eff;
	logic          rad2;

	always_comb begin
		if (image_width_q < MIN_DIM) begin
			w_eff = SW'(MIN_DIM);
		end else if (SW'(image_width_q) > SW'(MAX_WIDTH)) begin
			w_eff = SW'(MAX_WIDTH);
		end else begin
			w_eff = SW'(image_width_q);
		end
		if (image_height_q < MIN_DIM) begin
			h_eff = SW'(MIN_DIM);
		end else if (SW'(image_height_q) > SW'(MAX_HEIGHT)) begin
			h_eff = SW'(MAX_HEIGHT);
		end else begin
			h_eff = SW'(image_height_q);
		end
	end

	assign rad2 = (kernel_radius_q == RADIUS_5X5);

	// ------------------------------------------------------------------
	// Handshake. The whole pipeline moves while the skid entry is empty.
	// ------------------------------------------------------------------
	logic sk_valid_q;
	logic en;
	logic accept;

	assign en       = !sk_valid_q;
	assign in_stall = sk_valid_q;
	assign accept   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Raster position of the incoming pixel and its window classification.
	// ------------------------------------------------------------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] c_ext;
	logic [SW-1:0] r_ext;
	logic [SW-1:0] lim;
	logic [SW-1:0] rad_ext;
	logic [SW-1:0] row_ctr;
	logic [SW-1:0] col_ctr;
	bmf_meta_t     meta_in;

	assign c_ext   = SW'(col_q);
	assign r_ext   = SW'(row_q);
	assign lim     = rad2 ? SW'(4) : SW'(2);
	assign rad_ext = rad2 ? SW'(2) : SW'(1);
	assign row_ctr = r_ext - rad_ext;
	assign col_ctr = c_ext - rad_ext;

	always_comb begin
		meta_in.interior = (r_ext < h_eff) && (c_ext < w_eff) && (r_ext >= lim) && (c_ext >= lim);
		meta_in.last     = (r_ext == h_eff - SW'(1)) && (c_ext == w_eff - SW'(1));
		meta_in.rad2     = rad2;
		meta_in.row      = row_ctr[POS_W-1:0];
		meta_in.col      = col_ctr[POS_W-1:0];
	end

	// Advance the column, wrap at row end and at frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_ext + SW'(1) >= w_eff) begin
				col_q <= '0;
				if (r_ext + SW'(1) >= h_eff) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line store read. Row r-4+k sits in slot (r+k) mod 4, and the
	// new pixel overwrites slot r mod 4 after its old row is read out.
	// ------------------------------------------------------------------
	logic [STORE_LINES-1:0][PIX_W-1:0] ls_rd;
	logic                              valid_s1;
	bmf_meta_t                         meta_s1;
	logic [PIX_W-1:0]                  px_s1;
	logic [1:0]                        slot_s1;

	bmf_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.en    (accept),
		.slot  (row_q[1:0]),
		.addr  (col_q),
		.wdata (pixel),
		.rd    (ls_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_in;
			px_s1   <= pixel;
			slot_s1 <= row_q[1:0];
		end
	end

	// Sort the banks into window rows, oldest row first, and sum the column.
	logic [PIX_W-1:0]  col_px [STORE_LINES];
	logic [COL3_W-1:0] new_sum3;
	logic [COL5_W-1:0] new_sum5;

	always_comb begin
		for (int k = 0; k < STORE_LINES; k++) begin
			col_px[k] = ls_rd[slot_s1 + 2'(k)];
		end
		new_sum3 = COL3_W'(col_px[2]) + COL3_W'(col_px[3]) + COL3_W'(px_s1);
		new_sum5 = COL5_W'(col_px[0]) + COL5_W'(col_px[1]) + COL5_W'(new_sum3);
	end

	// ------------------------------------------------------------------
	// Stage 2: chain of window cells. Cell WIN-1 takes the new column, each
	// other cell takes its right neighbor, and cell 0 drops the oldest one.
	// ------------------------------------------------------------------
	logic [COL3_W-1:0] csum3 [WIN];
	logic [COL5_W-1:0] csum5 [WIN];
	logic              shift;
	logic              valid_s2;
	bmf_meta_t         meta_s2;

	assign shift = en && valid_s1;

	for (genvar k = 0; k < WIN; k++) begin : g_cell
		logic [COL3_W-1:0] feed3;
		logic [COL5_W-1:0] feed5;

		if (k == WIN - 1) begin : g_head
			assign feed3 = new_sum3;
			assign feed5 = new_sum5;
		end else begin : g_link
			assign feed3 = csum3[k+1];
			assign feed5 = csum5[k+1];
		end

		bmf_win_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.sum3_in (feed3),
			.sum5_in (feed5),
			.sum3    (csum3[k]),
			.sum5    (csum5[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			meta_s2 <= meta_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: window sum. The 3x3 window is the right three columns of
	// the bottom three rows; drop non-interior pixels here.
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] tot5;
	logic [SUM_W-1:0] tot3;
	logic             valid_s3;
	bmf_meta_t        meta_s3;
	logic [SUM_W-1:0] sum_s3;

	always_comb begin
		tot5 = '0;
		for (int k = 0; k < WIN; k++) begin
			tot5 = tot5 + SUM_W'(csum5[k]);
		end
		tot3 = SUM_W'(csum3[WIN-3]) + SUM_W'(csum3[WIN-2]) + SUM_W'(csum3[WIN-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2 && meta_s2.interior;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			meta_s3 <= meta_s2;
			sum_s3  <= meta_s2.rad2 ? tot5 : tot3;
		end
	end

	// Divide by 9 or 25 through a reciprocal multiply and shift.
	logic [DIV_K_W-1:0] k_sel;
	logic [PROD_W-1:0]  prod;
	logic [PIX_W-1:0]   res_mean;

	assign k_sel    = meta_s3.rad2 ? DIV_K_W'(DIV25_MUL) : DIV_K_W'(DIV9_MUL);
	assign prod     = PROD_W'(sum_s3) * PROD_W'(k_sel);
	assign res_mean = meta_s3.rad2 ? prod[DIV25_SHIFT +: PIX_W] : prod[DIV9_SHIFT +: PIX_W];

	// ------------------------------------------------------------------
	// Output register with one skid entry behind it. A result that meets a
	// stalled output parks in the skid entry, which then holds the pipeline.
	// ------------------------------------------------------------------
	logic             out_valid_q;
	logic [PIX_W-1:0] out_mean_q;
	logic [POS_W-1:0] out_row_q;
	logic [POS_W-1:0] out_col_q;
	logic             out_last_q;
	logic [PIX_W-1:0] sk_mean_q;
	logic [POS_W-1:0] sk_row_q;
	logic [POS_W-1:0] sk_col_q;
	logic             sk_last_q;
	logic             out_free;
	logic             res_valid;

	assign out_free  = !out_valid_q || !out_stall;
	assign res_valid = en && valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (sk_valid_q) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
				sk_valid_q  <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (out_free) begin
				out_mean_q <= sk_mean_q;
				out_row_q  <= sk_row_q;
				out_col_q  <= sk_col_q;
				out_last_q <= sk_last_q;
			end
		end else if (out_free) begin
			if (res_valid) begin
				out_mean_q <= res_mean;
				out_row_q  <= meta_s3.row;
				out_col_q  <= meta_s3.col;
				out_last_q <= meta_s3.last;
			end
		end else if (res_valid) begin
			sk_mean_q <= res_mean;
			sk_row_q  <= meta_s3.row;
			sk_col_q  <= meta_s3.col;
			sk_last_q <= meta_s3.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_value = out_mean_q;
	assign centre_row = out_row_q;
	assign centre_col = out_col_q;
	assign frame_last = out_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BMF_ASSERT_IMP(a_skid_behind_out, sk_valid_q, out_valid_q, "skid full with output empty")
	`BMF_ASSERT_IMP(a_skid_fill_cause, $rose(sk_valid_q), $past(out_valid_q && out_stall), "skid filled without a stalled output")
	`BMF_ASSERT_NXT(a_accept_enters, accept, valid_s1, "accepted pixel missing from stage 1")
	`BMF_ASSERT_NXT(a_hold_freezes, !en, $stable(valid_s2) && $stable(valid_s3), "pipeline moved while held")

endmodule
